/* rtl/lnr_pkg.sv */
// ----------------------------------------------------------------------------
// lnr_pkg: shared types for the line rasteriser
// Coordinate widths, request/response payloads and the classified command
// that passes from the front end to the stepper.
// ----------------------------------------------------------------------------
package lnr_pkg;

   localparam int COORD_BITS = 12;
   // decision variable spans (-2*dmaj, 2*dmin], needs two guard bits plus sign
   localparam int DEC_BITS   = COORD_BITS + 3;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic        [COORD_BITS-1:0] delta_type;

   typedef enum logic {
      KIND_START = 1'b0,
      KIND_STEP  = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type finish_x;
      coord_type finish_y;
   } req_type;

   typedef struct packed {
      coord_type pixel_x;
      coord_type pixel_y;
      logic      last_pixel;
   } rsp_type;

   // request after classification: absolute deltas and step directions
   typedef struct packed {
      kind_type  kind;
      coord_type start_x;
      coord_type start_y;
      coord_type finish_x;
      coord_type finish_y;
      delta_type abs_dx;
      delta_type abs_dy;
      logic      x_neg;
      logic      y_neg;
   } cmd_type;

endpackage

/* rtl/lnr_front.sv */
// ----------------------------------------------------------------------------
// lnr_front: request classifier
// Works out the endpoint deltas, their magnitudes and step directions so
// the stepper only has to compare and pick the major axis.
// ----------------------------------------------------------------------------
module lnr_front import lnr_pkg::*; (
   input  req_type req,
   output cmd_type cmd
);

   logic signed [COORD_BITS:0] dx;
   logic signed [COORD_BITS:0] dy;
   logic signed [COORD_BITS:0] dx_abs;
   logic signed [COORD_BITS:0] dy_abs;
   logic                       x_neg;
   logic                       y_neg;

   always_comb begin
      dx = (COORD_BITS+1)'(req.finish_x) - (COORD_BITS+1)'(req.start_x);
      dy = (COORD_BITS+1)'(req.finish_y) - (COORD_BITS+1)'(req.start_y);
      // a zero delta counts as a negative step
      x_neg  = dx[COORD_BITS] | (dx == '0);
      y_neg  = dy[COORD_BITS] | (dy == '0);
      dx_abs = x_neg ? -dx : dx;
      dy_abs = y_neg ? -dy : dy;

      cmd.kind     = req.kind;
      cmd.start_x  = req.start_x;
      cmd.start_y  = req.start_y;
      cmd.finish_x = req.finish_x;
      cmd.finish_y = req.finish_y;
      cmd.abs_dx   = dx_abs[COORD_BITS-1:0];
      cmd.abs_dy   = dy_abs[COORD_BITS-1:0];
      cmd.x_neg    = x_neg;
      cmd.y_neg    = y_neg;
   end

endmodule

/* rtl/lnr_queue.sv */
// ----------------------------------------------------------------------------
// lnr_queue: command queue
// Small register FIFO between classifier and stepper; push and pop may
// happen in the same cycle.
// ----------------------------------------------------------------------------
module lnr_queue import lnr_pkg::*; #(
   parameter int DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push_valid,
   output logic    push_ready,
   input  cmd_type push_data,
   output logic    pop_valid,
   input  logic    pop_ready,
   output cmd_type pop_data
);

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   cmd_type             mem_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;
   logic                push;
   logic                pop;

   assign push_ready = (count_ff != CNT_BITS'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid & push_ready;
   assign pop        = pop_valid & pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : wr_ptr_ff + PTR_BITS'(1);
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH-1)) ? '0 : rd_ptr_ff + PTR_BITS'(1);
      end
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

/* rtl/lnr_back.sv */
// ----------------------------------------------------------------------------
// lnr_back: Bresenham stepper
// Holds the line state, sets it up on a start command and emits one pixel
// per step command on a live line into a registered response slot.
// ----------------------------------------------------------------------------
module lnr_back import lnr_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    cmd_valid,
   output logic    cmd_ready,
   input  cmd_type cmd,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   logic                         active_ff,     active_in;
   coord_type                    major_pos_ff,  major_pos_in;
   coord_type                    minor_pos_ff,  minor_pos_in;
   coord_type                    major_end_ff,  major_end_in;
   logic                         major_neg_ff,  major_neg_in;
   logic                         minor_neg_ff,  minor_neg_in;
   logic                         swapped_ff,    swapped_in;
   logic signed [DEC_BITS-1:0]   decision_ff,   decision_in;
   logic [COORD_BITS:0]          inc_str_ff,    inc_str_in;
   logic signed [COORD_BITS+1:0] inc_diag_ff,   inc_diag_in;
   logic                         rsp_valid_ff,  rsp_valid_in;
   rsp_type                      rsp_ff,        rsp_in;

   logic       take;
   logic       emit;
   logic       swap;
   delta_type  d_maj;
   delta_type  d_min;
   coord_type  next_major;
   logic       last;

   assign cmd_ready   = ~rsp_valid_ff | rsp_ready;
   assign take        = cmd_valid & cmd_ready;
   assign emit        = take & (cmd.kind == KIND_STEP) & active_ff;
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   always_comb begin
      active_in    = active_ff;
      major_pos_in = major_pos_ff;
      minor_pos_in = minor_pos_ff;
      major_end_in = major_end_ff;
      major_neg_in = major_neg_ff;
      minor_neg_in = minor_neg_ff;
      swapped_in   = swapped_ff;
      decision_in  = decision_ff;
      inc_str_in   = inc_str_ff;
      inc_diag_in  = inc_diag_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;

      swap  = (cmd.abs_dx < cmd.abs_dy);
      d_maj = swap ? cmd.abs_dy : cmd.abs_dx;
      d_min = swap ? cmd.abs_dx : cmd.abs_dy;

      next_major = major_pos_ff + (major_neg_ff ? '1 : COORD_BITS'(1));
      last       = (next_major == major_end_ff);

      if (take && cmd.kind == KIND_START) begin
         swapped_in   = swap;
         major_pos_in = swap ? cmd.start_y  : cmd.start_x;
         minor_pos_in = swap ? cmd.start_x  : cmd.start_y;
         major_end_in = swap ? cmd.finish_y : cmd.finish_x;
         major_neg_in = swap ? cmd.y_neg    : cmd.x_neg;
         minor_neg_in = swap ? cmd.x_neg    : cmd.y_neg;
         decision_in  = $signed({2'b00, d_min, 1'b0}) - $signed({3'b000, d_maj});
         inc_str_in   = {d_min, 1'b0};
         inc_diag_in  = $signed({1'b0, d_min, 1'b0}) - $signed({1'b0, d_maj, 1'b0});
         active_in    = swap ? (cmd.start_y != cmd.finish_y)
                             : (cmd.start_x != cmd.finish_x);
      end else if (emit) begin
         rsp_in.pixel_x    = swapped_ff ? minor_pos_ff : major_pos_ff;
         rsp_in.pixel_y    = swapped_ff ? major_pos_ff : minor_pos_ff;
         rsp_in.last_pixel = last;
         rsp_valid_in      = 1'b1;
         if (decision_ff <= 0) begin
            decision_in = decision_ff + $signed({2'b00, inc_str_ff});
         end else begin
            minor_pos_in = minor_pos_ff + (minor_neg_ff ? '1 : COORD_BITS'(1));
            decision_in  = decision_ff + DEC_BITS'(inc_diag_ff);
         end
         major_pos_in = next_major;
         if (last) begin
            active_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         active_ff    <= active_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      major_pos_ff <= major_pos_in;
      minor_pos_ff <= minor_pos_in;
      major_end_ff <= major_end_in;
      major_neg_ff <= major_neg_in;
      minor_neg_ff <= minor_neg_in;
      swapped_ff   <= swapped_in;
      decision_ff  <= decision_in;
      inc_str_ff   <= inc_str_in;
      inc_diag_ff  <= inc_diag_in;
      rsp_ff       <= rsp_in;
   end

endmodule

/* rtl/line_rasterizer.sv */
// A step request is queued, then its pixel is registered in the response slot for rsp_valid.
// Throughput: one request per cycle while rsp_ready holds; one pixel per clock on live steps.
// The rate is set by the stepper: one decision add and one end compare per request.
// Reset (synchronous, active high) empties the command queue and the response slot
// and drops any line in progress; the first request may follow straight after reset.
// ----------------------------------------------------------------------------
// line_rasterizer: Bresenham line generator, all octants
// A classifier front end feeds a short command queue; the stepper behind it
// owns the line state and a registered response slot, so either side can
// stall without holding up the other.
// ----------------------------------------------------------------------------
module line_rasterizer import lnr_pkg::*; #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic    clock,
   input  logic    reset,
   // request channel: start a line or step it
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_payload,
   // response channel: one pixel per step while a line is live
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_payload
);

   cmd_type cmd_front;  // classified request from the front end
   cmd_type cmd_queued; // head of the queue
   logic    cmd_valid;
   logic    cmd_ready;

   // front end: deltas, magnitudes and step directions
   lnr_front u_front (
      .req (req_payload),
      .cmd (cmd_front)
   );

   // decoupling queue; req_ready depends only on its fill level
   lnr_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (req_valid),
      .push_ready (req_ready),
      .push_data  (cmd_front),
      .pop_valid  (cmd_valid),
      .pop_ready  (cmd_ready),
      .pop_data   (cmd_queued)
   );

   // back end: line setup on start, one pixel per step; a step with no
   // line live, and every start, is consumed without a response
   lnr_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cmd_valid   (cmd_valid),
      .cmd_ready   (cmd_ready),
      .cmd         (cmd_queued),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule
